FILE: rtl/twm_pkg.sv
// shared types, constants and byte classification helpers for the
// whole-word match counter; no dependencies
package twm_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int TERM_LEN_W  = 6;
    localparam int TERM_IW     = 6;
    localparam int TERM_CAP    = 48;
    localparam int CFG_IW      = 4;
    localparam int CFG_DW      = 64;
    localparam int TERM_WORDS  = 6;
    localparam logic [TERM_LEN_W-1:0] TERM_LEN_RESET = TERM_LEN_W'(4);

    typedef enum logic [CFG_IW-1:0] {
        REG_TERM_LENGTH   = 4'd0,
        REG_CASE_SENS     = 4'd1,
        REG_TERM_A        = 4'd2,
        REG_TERM_B        = 4'd3,
        REG_TERM_C        = 4'd4,
        REG_TERM_D        = 4'd5,
        REG_TERM_E        = 4'd6,
        REG_TERM_F        = 4'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLOSE,
        S_RT_RD,
        S_RT_CHK,
        S_LT_RD,
        S_LT_CHK,
        S_CMP_LEN,
        S_CMP_RD,
        S_CMP_CHK,
        S_DONE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TERM_IW-1:0] term_len;   // already capped at TERM_CAP
        logic               case_sens;
    } t_term_cfg;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic in_right_set(input logic [BYTE_W-1:0] c);
        return is_space(c) || c == "." || c == "," || c == "!" || c == "?" ||
               c == ":" || c == ";" || c == "-" || c == "'";
    endfunction

    function automatic logic in_left_set(input logic [BYTE_W-1:0] c);
        return is_space(c) || c == "-";
    endfunction

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                               input logic case_sens);
        if (!case_sens && c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

FILE: rtl/twm_if.sv
// valid/ready channel interfaces: text input, count result, register writes
// depends on twm_pkg for field widths
interface twm_in_if;
    logic                        valid;
    logic                        ready;
    logic [twm_pkg::BYTE_W-1:0]  text_byte;
    logic                        end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface twm_out_if;
    logic                        valid;
    logic                        ready;
    logic [twm_pkg::COUNT_W-1:0] match_count;
    logic                        long_token_seen;

    modport source (output valid, output match_count, output long_token_seen, input ready);
    modport sink   (input valid, input match_count, input long_token_seen, output ready);
endinterface

interface twm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [twm_pkg::CFG_IW-1:0]  index;
    logic [twm_pkg::CFG_DW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/twm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module twm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/twm_cfg.sv
// configuration register file: term length, case mode and the 48 term bytes
// depends on twm_pkg and twm_cfg_if
module twm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    twm_cfg_if.sink                        i_cfg,
    input  logic [twm_pkg::TERM_IW-1:0]    i_term_idx,
    output logic [twm_pkg::BYTE_W-1:0]     o_term_byte,
    output twm_pkg::t_term_cfg             o_term_cfg
);
    import twm_pkg::*;

    logic [TERM_LEN_W-1:0] r_term_len;
    logic                  r_case_sens;
    logic [CFG_DW-1:0]     r_term_word [TERM_WORDS];
    logic [CFG_DW-1:0]     w_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len  <= TERM_LEN_RESET;
            r_case_sens <= 1'b0;
            for (int k = 0; k < TERM_WORDS; k++) begin
                r_term_word[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TERM_LENGTH: r_term_len  <= i_cfg.data[TERM_LEN_W-1:0];
                REG_CASE_SENS:   r_case_sens <= i_cfg.data[0];
                REG_TERM_A:      r_term_word[0] <= i_cfg.data;
                REG_TERM_B:      r_term_word[1] <= i_cfg.data;
                REG_TERM_C:      r_term_word[2] <= i_cfg.data;
                REG_TERM_D:      r_term_word[3] <= i_cfg.data;
                REG_TERM_E:      r_term_word[4] <= i_cfg.data;
                REG_TERM_F:      r_term_word[5] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // byte i lives in word i/8, lane i%8
    always_comb begin
        unique case (i_term_idx[TERM_IW-1:3])
            3'd0:    w_word = r_term_word[0];
            3'd1:    w_word = r_term_word[1];
            3'd2:    w_word = r_term_word[2];
            3'd3:    w_word = r_term_word[3];
            3'd4:    w_word = r_term_word[4];
            default: w_word = r_term_word[5];
        endcase
    end

    assign o_term_byte = w_word[{i_term_idx[2:0], 3'b000} +: BYTE_W];

    assign o_term_cfg.term_len  = (r_term_len > TERM_LEN_W'(TERM_CAP)) ?
                                  TERM_IW'(TERM_CAP) : TERM_IW'(r_term_len);
    assign o_term_cfg.case_sens = r_case_sens;

endmodule

FILE: rtl/twm_scan.sv
// token buffer and sequencer: stores token bytes in the word ram, then
// trims and compares them one ram read at a time; holds the result register
// depends on twm_pkg, twm_if, twm_ram
module twm_scan #(
    parameter int WORD_MAX = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    twm_in_if.sink                         i_in,
    twm_out_if.source                      o_out,
    input  twm_pkg::t_term_cfg             i_term_cfg,
    input  logic [twm_pkg::BYTE_W-1:0]     i_term_byte,
    output logic [twm_pkg::TERM_IW-1:0]    o_term_idx
);
    import twm_pkg::*;

    localparam int AW = $clog2(WORD_MAX);
    localparam int LW = $clog2(WORD_MAX + 1);

    t_state               r_state, n_state;
    logic [LW-1:0]        r_len, n_len;
    logic                 r_too_long, n_too_long;
    logic [LW-1:0]        r_hi, n_hi;
    logic [LW-1:0]        r_lo, n_lo;
    logic [TERM_IW-1:0]   r_idx, n_idx;
    logic                 r_last, n_last;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic                 r_out_long, n_out_long;

    logic                 w_in_acc;
    logic                 w_space;
    logic                 w_has_token;
    logic                 w_room;
    logic                 w_out_free;
    logic [LW-1:0]        w_hi_m1;
    logic [LW-1:0]        w_pos;
    logic                 w_len_eq;
    logic                 w_byte_eq;
    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [BYTE_W-1:0]    w_q;
    logic [COUNT_W-1:0]   w_count_inc;

    twm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WORD_MAX)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_in.text_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_space     = is_space(i_in.text_byte);
    assign w_has_token = (r_len != '0) || r_too_long;
    assign w_room      = r_len < LW'(WORD_MAX);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_hi_m1     = r_hi - LW'(1);
    assign w_pos       = r_lo + LW'(r_idx);
    assign w_len_eq    = (r_hi - r_lo) == LW'(i_term_cfg.term_len);
    assign w_byte_eq   = fold(w_q, i_term_cfg.case_sens) ==
                         fold(i_term_byte, i_term_cfg.case_sens);
    assign w_we        = w_in_acc && !w_space && w_room;
    assign w_count_inc = (r_count == '1) ? r_count : r_count + COUNT_W'(1);
    assign o_term_idx  = r_idx;

    always_comb begin
        unique case (r_state)
            S_RT_RD: w_raddr = w_hi_m1[AW-1:0];
            S_LT_RD: w_raddr = r_lo[AW-1:0];
            default: w_raddr = w_pos[AW-1:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_space) begin
                        if (w_has_token) begin
                            n_state = S_CLOSE;
                        end else if (i_in.end_of_text) begin
                            n_state = S_EMIT;
                        end
                    end else if (i_in.end_of_text) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE:   n_state = r_too_long ? S_DONE : S_RT_RD;
            S_RT_RD:   n_state = (r_hi == '0) ? S_LT_RD : S_RT_CHK;
            S_RT_CHK:  n_state = in_right_set(w_q) ? S_RT_RD : S_LT_RD;
            S_LT_RD:   n_state = (r_lo >= r_hi) ? S_CMP_LEN : S_LT_CHK;
            S_LT_CHK:  n_state = in_left_set(w_q) ? S_LT_RD : S_CMP_LEN;
            S_CMP_LEN: n_state = w_len_eq ? S_CMP_RD : S_DONE;
            S_CMP_RD:  n_state = (r_idx == i_term_cfg.term_len) ? S_DONE : S_CMP_CHK;
            S_CMP_CHK: n_state = w_byte_eq ? S_CMP_RD : S_DONE;
            S_DONE:    n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT:    n_state = w_out_free ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_len       = r_len;
        n_too_long  = r_too_long;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_idx       = r_idx;
        n_last      = r_last;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_count = r_out_count;
        n_out_long  = r_out_long;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_last = i_in.end_of_text;
                    if (!w_space) begin
                        if (w_room) begin
                            n_len = r_len + LW'(1);
                        end else begin
                            n_too_long = 1'b1;
                        end
                    end
                end
            end
            S_CLOSE: begin
                n_hi = r_len;
                n_lo = '0;
                if (r_too_long) begin
                    n_ovf = 1'b1;
                end
            end
            S_RT_CHK: begin
                if (in_right_set(w_q)) begin
                    n_hi = w_hi_m1;
                end
            end
            S_LT_CHK: begin
                if (in_left_set(w_q)) begin
                    n_lo = r_lo + LW'(1);
                end
            end
            S_CMP_LEN: n_idx = '0;
            S_CMP_RD: begin
                if (r_idx == i_term_cfg.term_len) begin
                    n_count = w_count_inc;
                end
            end
            S_CMP_CHK: n_idx = r_idx + TERM_IW'(1);
            S_DONE: begin
                n_len      = '0;
                n_too_long = 1'b0;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_long  = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_too_long  <= 1'b0;
            r_last      <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_too_long  <= n_too_long;
            r_last      <= n_last;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_idx       <= n_idx;
        r_out_count <= n_out_count;
        r_out_long  <= n_out_long;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.match_count     = r_out_count;
    assign o_out.long_token_seen = r_out_long;

    // buffer is only written while taking a byte in
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("word ram written outside idle");

    // left trim and compare never walk past the right end
    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LT_CHK || r_state == S_CMP_RD || r_state == S_CMP_CHK)
        |-> (r_lo <= r_hi) && (r_hi <= r_len))
        else $error("trim window out of order");

    // count only moves up until the result is loaded
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT) |=> (r_count >= $past(r_count)))
        else $error("match count went backwards");

endmodule

FILE: rtl/trimmed_word_match_counter.sv
// Whole-word occurrence counter. Bytes arrive one per transaction on i_in and
// are split into tokens at ASCII whitespace; a token is trimmed on the right
// (whitespace . , ! ? : ; - ') and the left (whitespace -), optionally
// case-folded and compared with the term held in the register file. A byte
// that does not end a token leaves the block idle and ready for the next byte.
// Closing a token is walked through the single read port of the word ram, a
// read state and a check state per byte visited; the walk is shorter when the
// trim empties the token or the lengths differ, and a token over WORD_MAX bytes
// skips it. The byte marked end_of_text also loads the result register, which
// waits while an earlier result still waits on o_out. Tokens over WORD_MAX
// bytes never match and set long_token_seen. The count saturates at 2^32-1.
// No clearing pass follows reset; the user must write registers on i_cfg only
// while the block is idle, which the block itself does not enforce.
module trimmed_word_match_counter #(
    parameter int WORD_MAX = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    twm_in_if.sink    i_in,
    twm_out_if.source o_out,
    twm_cfg_if.sink   i_cfg
);
    import twm_pkg::*;

    t_term_cfg            w_term_cfg;
    logic [TERM_IW-1:0]   w_term_idx;
    logic [BYTE_W-1:0]    w_term_byte;

    twm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_term_idx  (w_term_idx),
        .o_term_byte (w_term_byte),
        .o_term_cfg  (w_term_cfg)
    );

    twm_scan #(
        .WORD_MAX (WORD_MAX)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_term_cfg  (w_term_cfg),
        .i_term_byte (w_term_byte),
        .o_term_idx  (w_term_idx)
    );

endmodule

FILE: test/twm_checker.sv
`timescale 1ns / 1ps
// checker for the whole-word match counter: tracks register writes and the
// byte stream, predicts every count result and compares it field by field
// depends on twm_pkg and the channel interfaces of twm_if.sv
module twm_checker #(
    parameter int WORD_MAX = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    twm_in_if    i_in,
    twm_out_if   i_out,
    twm_cfg_if   i_cfg,
    output int   o_err_count,
    output int   o_pending
);
    import twm_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               long_seen;
    } t_count_result;

    // mirror of the block state
    logic [BYTE_W-1:0]              word_buf [WORD_MAX];
    logic [$clog2(WORD_MAX+1)-1:0]  word_len;
    logic                           word_overrun;
    logic                           overrun_seen;
    logic [COUNT_W-1:0]             match_tally;

    // mirror of the register file
    logic [TERM_LEN_W-1:0]          term_len_r;
    logic                           exact_case;
    logic [CFG_DW-1:0]              term_word [TERM_WORDS];

    t_count_result                  pending_counts [$];

    initial o_err_count = 0;

    task automatic report_err(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        o_err_count++;
    endtask

    function automatic logic blank_byte(input logic [BYTE_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic trail_byte(input logic [BYTE_W-1:0] c);
        return blank_byte(c) || (c inside {".", ",", "!", "?", ":", ";", "-", "'"});
    endfunction

    function automatic logic lead_byte(input logic [BYTE_W-1:0] c);
        return blank_byte(c) || c == "-";
    endfunction

    function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] c);
        if (!exact_case && c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] term_at(input int i);
        return term_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic close_word();
        int   lo;
        int   hi;
        int   eff;
        logic hit;
        if (word_overrun) begin
            overrun_seen = 1'b1;
        end else begin
            hi = int'(word_len);
            lo = 0;
            while (hi > 0 && trail_byte(word_buf[hi-1])) hi--;
            while (lo < hi && lead_byte(word_buf[lo])) lo++;
            eff = (int'(term_len_r) > TERM_CAP) ? TERM_CAP : int'(term_len_r);
            hit = ((hi - lo) == eff);
            for (int i = 0; hit && i < eff; i++) begin
                if (lower_byte(word_buf[lo+i]) != lower_byte(term_at(i))) hit = 1'b0;
            end
            if (hit && match_tally != '1) match_tally++;
        end
        word_len     = '0;
        word_overrun = 1'b0;
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] c, input logic last);
        if (blank_byte(c)) begin
            if (word_len != 0 || word_overrun) close_word();
        end else if (word_len < WORD_MAX) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            word_overrun = 1'b1;
        end
        if (last) begin
            if (word_len != 0 || word_overrun) close_word();
            pending_counts.push_back('{count: match_tally, long_seen: overrun_seen});
            word_len     = '0;
            word_overrun = 1'b0;
            match_tally  = '0;
            overrun_seen = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_count_result exp_r;
        if (!i_rst_n) begin
            word_len     = '0;
            word_overrun = 1'b0;
            overrun_seen = 1'b0;
            match_tally  = '0;
            term_len_r   = TERM_LEN_RESET;
            exact_case   = 1'b0;
            for (int k = 0; k < TERM_WORDS; k++) term_word[k] = '0;
            pending_counts.delete();
        end else begin
            // results first, so a result never pairs with a byte taken at the same edge
            if (i_out.valid && i_out.ready) begin
                if (pending_counts.size() == 0) begin
                    report_err($sformatf("result count=%0d long=%0b with nothing pending",
                                         i_out.match_count, i_out.long_token_seen));
                end else begin
                    exp_r = pending_counts.pop_front();
                    if (i_out.match_count !== exp_r.count)
                        report_err($sformatf("match_count got %0d, expected %0d",
                                             i_out.match_count, exp_r.count));
                    if (i_out.long_token_seen !== exp_r.long_seen)
                        report_err($sformatf("long_token_seen got %0b, expected %0b",
                                             i_out.long_token_seen, exp_r.long_seen));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TERM_LENGTH: term_len_r   = i_cfg.data[TERM_LEN_W-1:0];
                    REG_CASE_SENS:   exact_case   = i_cfg.data[0];
                    REG_TERM_A:      term_word[0] = i_cfg.data;
                    REG_TERM_B:      term_word[1] = i_cfg.data;
                    REG_TERM_C:      term_word[2] = i_cfg.data;
                    REG_TERM_D:      term_word[3] = i_cfg.data;
                    REG_TERM_E:      term_word[4] = i_cfg.data;
                    REG_TERM_F:      term_word[5] = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) absorb_byte(i_in.text_byte, i_in.end_of_text);
        end
        o_pending = pending_counts.size();
    end

endmodule

FILE: test/tb_trimmed_word_match_counter.sv
`timescale 1ns / 1ps
// top of the whole-word match counter testbench: clock, reset, register
// programming and text stimulus; prediction lives in twm_checker
// depends on twm_pkg, twm_if.sv, twm_checker.sv and the block itself
module tb_trimmed_word_match_counter;
    import twm_pkg::*;

    localparam int WORD_MAX      = 64;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_BYTES   = 400;
    localparam int PHASE_TEXTS   = 4;
    localparam int TEXTS_PER_CFG = 2;
    localparam int FIRST_SPARE_IDX = TERM_WORDS + 2;
    localparam int LAST_IDX        = (1 << CFG_IW) - 1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HYPHEN = "-";

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int err_count;
    int pending;
    int cycle_cnt    = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bytes_sent;
    int cfg_round    = 0;

    // copy of the programmed term, used to build matching tokens
    logic [7:0] term_mirror [TERM_CAP];
    int         term_eff;
    logic       exact_mode;
    logic [7:0] text_q [$];

    twm_in_if  in_ch ();
    twm_out_if out_ch ();
    twm_cfg_if cfg_ch ();

    trimmed_word_match_counter #(.WORD_MAX(WORD_MAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    twm_checker #(.WORD_MAX(WORD_MAX)) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    function automatic logic [7:0] rand_trail();
        case ($urandom_range(7))
            0:       return ".";
            1:       return ",";
            2:       return "!";
            3:       return "?";
            4:       return ":";
            5:       return ";";
            6:       return CH_HYPHEN;
            default: return "'";
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if (((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) && $urandom_range(1))
            return b ^ 8'h20;
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        bytes_sent += text_q.size();
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop the stream, let every count come back, then let the block settle
    task automatic wait_counts_done();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_term(input int len_code, input int style, input logic exact);
        logic [CFG_DW-1:0] w;
        for (int i = 0; i < TERM_CAP; i++) begin
            if (style < 4)
                term_mirror[i] = $urandom_range(1) ? 8'($urandom_range(90, 65))
                                                   : 8'($urandom_range(122, 97));
            else if (style < 6)
                term_mirror[i] = rand_plain();
            else if (style == 6)
                term_mirror[i] = 8'hFF;
            else
                term_mirror[i] = 8'h00;
        end
        term_eff   = (len_code > TERM_CAP) ? TERM_CAP : len_code;
        exact_mode = exact;
        for (int k = 0; k < TERM_WORDS; k++) begin
            for (int j = 0; j < 8; j++) w[j*8 +: 8] = term_mirror[k*8 + j];
            write_reg(CFG_IW'(REG_TERM_A + k), w);
        end
        // junk in the unused upper data bits
        w = {$urandom, $urandom};
        w[TERM_LEN_W-1:0] = TERM_LEN_W'(len_code);
        write_reg(REG_TERM_LENGTH, w);
        w = {$urandom, $urandom};
        w[0] = exact;
        write_reg(REG_CASE_SENS, w);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IW'($urandom_range(LAST_IDX, FIRST_SPARE_IDX)), {$urandom, $urandom});
        end_writes();
    endtask

    task automatic build_text();
        int         ntok;
        int         kind;
        int         n;
        int         pos;
        logic [7:0] b;
        text_q.delete();
        if ($urandom_range(3) == 0) text_q.push_back(rand_blank());
        ntok = $urandom_range(6, 1);
        for (int t = 0; t < ntok; t++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                // the term wrapped in strippable characters
                n = $urandom_range(2);
                repeat (n) text_q.push_back(CH_HYPHEN);
                for (int i = 0; i < term_eff; i++) begin
                    b = term_mirror[i];
                    if (!exact_mode || $urandom_range(7) == 0) b = flip_case(b);
                    text_q.push_back(b);
                end
                n = $urandom_range(3);
                repeat (n) text_q.push_back(rand_trail());
            end else if (kind < 55) begin
                // near miss: one bit off, one byte short or one byte long
                pos = text_q.size();
                for (int i = 0; i < term_eff; i++) text_q.push_back(term_mirror[i]);
                case ($urandom_range(2))
                    0: if (term_eff > 0) begin
                        n = pos + $urandom_range(term_eff - 1);
                        text_q[n] = text_q[n] ^ (8'h01 << $urandom_range(7));
                    end
                    1: if (term_eff > 0) void'(text_q.pop_back());
                    default: text_q.push_back(rand_plain());
                endcase
            end else if (kind < 70) begin
                n = $urandom_range(8, 1);
                repeat (n) text_q.push_back(rand_plain());
            end else if (kind < 78) begin
                // trims down to nothing
                n = $urandom_range(3, 1);
                repeat (n) text_q.push_back($urandom_range(1) ? CH_HYPHEN : rand_trail());
            end else if (kind < 86) begin
                // term behind hyphens, total length around the buffer size
                n = $urandom_range(70, 62) - term_eff;
                repeat (n) text_q.push_back(CH_HYPHEN);
                for (int i = 0; i < term_eff; i++) text_q.push_back(term_mirror[i]);
            end else if (kind < 92) begin
                n = $urandom_range(130, 60);
                repeat (n) text_q.push_back(rand_plain());
            end else begin
                n = $urandom_range(4, 1);
                repeat (n) text_q.push_back($urandom_range(1) ? 8'h00 : 8'hFF);
            end
            if (t < ntok - 1 || $urandom_range(1)) begin
                n = $urandom_range(2, 1);
                repeat (n) text_q.push_back(rand_blank());
            end
        end
        if (text_q.size() == 0) text_q.push_back(rand_blank());
    endtask

    initial begin
        int len_code;
        in_ch.valid       = 1'b0;
        in_ch.text_byte   = '0;
        in_ch.end_of_text = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 6;
        rcv_idle_pct = 68;

        // reset term is four zero bytes: bare, then wrapped; final byte is a token byte
        text_q = '{8'h00, 8'h00, 8'h00, 8'h00, CH_LF,
                   CH_HYPHEN, 8'h00, 8'h00, 8'h00, 8'h00, ".", "'", CH_CR,
                   CH_SPACE, 8'hFF};
        send_text();
        wait_counts_done();

        // empty term matches a token of punctuation only; final byte is whitespace
        write_reg(REG_TERM_LENGTH, '0);
        end_writes();
        text_q = '{CH_HYPHEN, ".", CH_VT, CH_FF, CH_TAB};
        send_text();
        wait_counts_done();

        // folded compare against a mixed-case term
        write_reg(REG_TERM_A, 64'h4162);
        write_reg(REG_TERM_LENGTH, 64'd2);
        write_reg(REG_CASE_SENS, '0);
        end_writes();
        text_q = '{"a", "B"};
        send_text();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 6;
                    rcv_idle_pct = 68;
                end
                1: begin
                    snd_idle_pct = 68;
                    rcv_idle_pct = 6;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            bytes_sent = 0;
            for (int texts = 0; bytes_sent < PHASE_BYTES || texts < PHASE_TEXTS; texts++) begin
                if (texts % TEXTS_PER_CFG == 0) begin
                    wait_counts_done();
                    case (cfg_round)
                        0: len_code = TERM_CAP;
                        1: len_code = 0;
                        2: len_code = (1 << TERM_LEN_W) - 1;
                        3: len_code = 1;
                        default: begin
                            case ($urandom_range(5))
                                0:       len_code = 0;
                                1:       len_code = 1;
                                2:       len_code = TERM_CAP;
                                3:       len_code = $urandom_range((1 << TERM_LEN_W) - 1,
                                                                   TERM_CAP + 1);
                                default: len_code = $urandom_range(10, 2);
                            endcase
                        end
                    endcase
                    cfg_round++;
                    program_term(len_code, $urandom_range(7), $urandom_range(1));
                end
                build_text();
                send_text();
            end
        end

        wait_counts_done();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
